// ===== rtl/core/assert_macros.svh =====
// Assertion helpers shared by the RTL. Synthesis builds define SYNTH.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTH
`define AMF_ASSERT_IMP(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");
`define AMF_ASSERT_NXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");
`else
`define AMF_ASSERT_IMP(label, clk, rst_n, ante, cons)
`define AMF_ASSERT_NXT(label, clk, rst_n, ante, cons)
`endif
`endif

// ===== rtl/core/amf_pkg.sv =====
`default_nettype none
package amf_pkg;
    localparam int PIXEL_BITS = 8;
    localparam int DIM_BITS   = 11;
    localparam int POS_BITS   = 10;
    localparam int WIN_BITS   = 3;
    localparam int Q_BITS     = 21;
    localparam int DELAY_BITS = 12;
    localparam int ADDR_BITS  = 13;
    localparam int RAM_DEPTH  = 8192;
    localparam int MAX_DIM    = 1024;
    localparam int N3         = 9;
    localparam int N5         = 25;
    localparam int N7         = 49;

    localparam logic [1:0] CFG_WIDTH  = 2'd0;
    localparam logic [1:0] CFG_HEIGHT = 2'd1;
    localparam logic [1:0] CFG_WINDOW = 2'd2;

    localparam logic [WIN_BITS-1:0] WIN3 = 3'd3;
    localparam logic [WIN_BITS-1:0] WIN5 = 3'd5;
    localparam logic [WIN_BITS-1:0] WIN7 = 3'd7;
    localparam logic [2:0] LAST_TAP = 3'd6;

    typedef enum logic [2:0] {
        S_IDLE, S_TOTAL, S_WRITE, S_READ, S_DRAIN, S_DECIDE
    } t_state;

    typedef struct packed {
        logic                  clear;
        logic                  valid;
        logic [PIXEL_BITS-1:0] value;
        logic                  in3;
        logic                  in5;
        logic                  centre;
    } t_ins;

    typedef struct packed {
        logic [PIXEL_BITS-1:0] pixel;
        logic [WIN_BITS-1:0]   win;
        logic                  kept;
    } t_decision;

    function automatic logic [DIM_BITS-1:0] clamp_dim(input logic [DIM_BITS-1:0] v);
        logic [DIM_BITS-1:0] r;
        r = v;
        if (v == '0) r = DIM_BITS'(1);
        else if (v > DIM_BITS'(MAX_DIM)) r = DIM_BITS'(MAX_DIM);
        return r;
    endfunction

    function automatic logic [WIN_BITS-1:0] clamp_win(input logic [WIN_BITS-1:0] v);
        logic [WIN_BITS-1:0] r;
        r = WIN3;
        unique case (v)
            3'd5, 3'd6: r = WIN5;
            3'd7:       r = WIN7;
            default:    r = WIN3;
        endcase
        return r;
    endfunction
endpackage
`default_nettype wire

// ===== rtl/core/adaptive_median_filter_top.sv =====
`default_nettype none
`include "assert_macros.svh"
// Adaptive median filter, 3x3 up to 7x7, for a grey raster pixel stream.
// Input channel: i_in_valid / o_in_stall carry one beat per item, a pixel
// or a flush marker. Each frame is width*height pixel beats followed by
// 3*width+3 flush beats. Output channel: o_out_valid / i_out_stall carry
// one filtered pixel per beat, starting once the stream is three rows and
// three columns ahead of it; the last pixel of the frame has end_of_frame.
// Geometry and start window are written through the configuration port and
// are latched when the first beat of a frame is accepted.
// Sequence: a beat that yields no result passes through a multiply step
// and a write step and returns to idle; a beat that yields a result takes
// a multiply step, a write step, 49 reads of the single line-store read
// port, one drain step and one decision step. The 49 reads set the rate.
// The result is presented at the end of that sequence.
// The result sits in an output register, so the next beat is accepted
// while it waits. If a second result is ready while the first is still
// stalled, the block holds in its decision cycle until the output frees.
// Reset clears control state, restores the register defaults (640 x 480,
// start window 3) and needs no clearing pass over the line store.
module adaptive_median_filter_top (
    input  wire logic                              i_clk,
    input  wire logic                              i_rst_n,
    input  wire logic                              i_in_valid,
    output logic                                   o_in_stall,
    input  wire logic [amf_pkg::PIXEL_BITS-1:0]    i_pixel,
    input  wire logic                              i_is_flush,
    input  wire logic                              i_cfg_wr_en,
    input  wire logic [1:0]                        i_cfg_index,
    input  wire logic [amf_pkg::DIM_BITS-1:0]      i_cfg_data,
    output logic                                   o_out_valid,
    input  wire logic                              i_out_stall,
    output logic      [amf_pkg::PIXEL_BITS-1:0]    o_filtered_pixel,
    output logic      [amf_pkg::WIN_BITS-1:0]      o_window_used,
    output logic                                   o_kept_centre,
    output logic                                   o_end_of_frame
);
    import amf_pkg::*;

    t_state r_state, n_state;

    // Configuration registers and the geometry latched for the frame.
    logic [DIM_BITS-1:0]   r_cfg_w, r_cfg_h, r_fw, r_fh;
    logic [WIN_BITS-1:0]   r_cfg_win, r_fwin;

    logic [Q_BITS-1:0]     r_q, r_total;
    logic [DELAY_BITS-1:0] r_delay;
    logic [PIXEL_BITS-1:0] r_pix;
    logic [POS_BITS-1:0]   r_er, r_ec;
    logic [2:0]            r_dr, r_dc;
    logic [ADDR_BITS-1:0]  r_addr, r_row_base;

    // Read pipeline stage: matches the registered memory read.
    logic                  r_p_valid, r_p_inb;
    logic [2:0]            r_p_dr, r_p_dc;

    logic                  r_out_valid;
    t_decision             r_out;
    logic                  r_out_eof;

    logic                  ram_we, ram_re, accept, out_block;
    logic [PIXEL_BITS-1:0] ram_rdata;
    logic [2*DIM_BITS-1:0] prod;
    logic [ADDR_BITS-1:0]  base, w13;
    logic [DIM_BITS:0]     row_sum, col_sum;
    logic                  inb, last_tap, emit, frame_end, eof;
    t_ins                  ins;
    t_decision             dec;

    assign accept    = i_in_valid && !o_in_stall;
    assign out_block = r_out_valid && i_out_stall;
    assign last_tap  = (r_dr == LAST_TAP) && (r_dc == LAST_TAP);
    assign emit      = r_q >= Q_BITS'(r_delay);
    assign frame_end = ({1'b0, r_q} + 22'd1) >= ({1'b0, r_total} + 22'(r_delay));
    assign eof       = ({1'b0, r_er} == r_fh - DIM_BITS'(1)) &&
                       ({1'b0, r_ec} == r_fw - DIM_BITS'(1));
    assign prod      = (2*DIM_BITS)'(r_fw) * (2*DIM_BITS)'(r_fh);
    assign w13       = ADDR_BITS'(r_fw);
    // Top-left tap of the window sits 6*width+6 entries behind the newest sample.
    assign base      = r_q[ADDR_BITS-1:0] - (w13 << 2) - (w13 << 1) - ADDR_BITS'(6);

    // A tap is inside the image when row er+dr-3 and column ec+dc-3 are in range.
    assign row_sum = (DIM_BITS+1)'(r_er) + (DIM_BITS+1)'(r_dr);
    assign col_sum = (DIM_BITS+1)'(r_ec) + (DIM_BITS+1)'(r_dc);
    assign inb = (row_sum >= 12'd3) && (row_sum < {1'b0, r_fh} + 12'd3) &&
                 (col_sum >= 12'd3) && (col_sum < {1'b0, r_fw} + 12'd3);

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE:   if (i_in_valid) n_state = S_TOTAL;
            S_TOTAL:  n_state = S_WRITE;
            S_WRITE:  n_state = emit ? S_READ : S_IDLE;
            S_READ:   if (last_tap) n_state = S_DRAIN;
            S_DRAIN:  n_state = S_DECIDE;
            S_DECIDE: if (!out_block) n_state = S_IDLE;
            default:  n_state = S_IDLE;
        endcase
    end

    always_comb begin
        o_in_stall = (r_state != S_IDLE);
        ram_we     = (r_state == S_WRITE) && (r_q < r_total);
        ram_re     = (r_state == S_READ);
    end

    always_comb begin
        ins.clear  = (r_state == S_WRITE);
        ins.valid  = r_p_valid;
        ins.value  = r_p_inb ? ram_rdata : '0;
        ins.in3    = (r_p_dr >= 3'd2) && (r_p_dr <= 3'd4) &&
                     (r_p_dc >= 3'd2) && (r_p_dc <= 3'd4);
        ins.in5    = (r_p_dr >= 3'd1) && (r_p_dr <= 3'd5) &&
                     (r_p_dc >= 3'd1) && (r_p_dc <= 3'd5);
        ins.centre = (r_p_dr == 3'd3) && (r_p_dc == 3'd3);
    end

    amf_ram #(.WIDTH(PIXEL_BITS), .DEPTH(RAM_DEPTH)) u_line_store (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (r_q[ADDR_BITS-1:0]),
        .i_wdata (r_pix),
        .i_re    (ram_re),
        .i_raddr (r_addr),
        .o_rdata (ram_rdata)
    );

    amf_rank u_rank (
        .i_clk       (i_clk),
        .i_ins       (ins),
        .i_start_win (r_fwin),
        .o_dec       (dec)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_cfg_w     <= DIM_BITS'(640);
            r_cfg_h     <= DIM_BITS'(480);
            r_cfg_win   <= WIN3;
            r_fw        <= DIM_BITS'(640);
            r_fh        <= DIM_BITS'(480);
            r_fwin      <= WIN3;
            r_q         <= '0;
            r_er        <= '0;
            r_ec        <= '0;
            r_p_valid   <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_p_valid <= ram_re;
            if (i_cfg_wr_en) begin
                case (i_cfg_index)
                    CFG_WIDTH:  r_cfg_w   <= i_cfg_data;
                    CFG_HEIGHT: r_cfg_h   <= i_cfg_data;
                    CFG_WINDOW: r_cfg_win <= i_cfg_data[WIN_BITS-1:0];
                    default:    ;
                endcase
            end
            if (accept && r_q == '0) begin
                r_fw   <= clamp_dim(r_cfg_w);
                r_fh   <= clamp_dim(r_cfg_h);
                r_fwin <= clamp_win(r_cfg_win);
            end
            if (r_state == S_WRITE) r_q <= frame_end ? '0 : r_q + Q_BITS'(1);
            if (r_state == S_DECIDE && !out_block) begin
                r_out_valid <= 1'b1;
                if (eof) begin
                    r_er <= '0;
                    r_ec <= '0;
                end else if ({1'b0, r_ec} == r_fw - DIM_BITS'(1)) begin
                    r_ec <= '0;
                    r_er <= r_er + POS_BITS'(1);
                end else begin
                    r_ec <= r_ec + POS_BITS'(1);
                end
            end else if (r_out_valid && !i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) r_pix <= i_is_flush ? '0 : i_pixel;
        if (r_state == S_TOTAL) begin
            r_total <= prod[Q_BITS-1:0];
            r_delay <= DELAY_BITS'(r_fw) + DELAY_BITS'({r_fw, 1'b0}) + DELAY_BITS'(3);
        end
        if (r_state == S_WRITE) begin
            r_addr     <= base;
            r_row_base <= base;
            r_dr       <= '0;
            r_dc       <= '0;
        end
        if (r_state == S_READ) begin
            r_p_inb <= inb;
            r_p_dr  <= r_dr;
            r_p_dc  <= r_dc;
            if (r_dc == LAST_TAP) begin
                r_dc       <= '0;
                r_dr       <= r_dr + 3'd1;
                r_addr     <= r_row_base + w13;
                r_row_base <= r_row_base + w13;
            end else begin
                r_dc   <= r_dc + 3'd1;
                r_addr <= r_addr + ADDR_BITS'(1);
            end
        end
        if (r_state == S_DECIDE && !out_block) begin
            r_out     <= dec;
            r_out_eof <= eof;
        end
    end

    assign o_out_valid      = r_out_valid;
    assign o_filtered_pixel = r_out.pixel;
    assign o_window_used    = r_out.win;
    assign o_kept_centre    = r_out.kept;
    assign o_end_of_frame   = r_out_eof;

    `AMF_ASSERT_IMP(a_out_from_decide, i_clk, i_rst_n, $rose(r_out_valid), $past(r_state == S_DECIDE))
    `AMF_ASSERT_IMP(a_tap_from_read, i_clk, i_rst_n, r_p_valid, $past(r_state == S_READ))
    `AMF_ASSERT_NXT(a_decide_loads, i_clk, i_rst_n, (r_state == S_DECIDE) && !out_block, r_out_valid)
    `AMF_ASSERT_IMP(a_no_write_in_read, i_clk, i_rst_n, ram_re, !ram_we)
endmodule
`default_nettype wire

// ===== rtl/core/amf_ram.sv =====
`default_nettype none
module amf_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 8192
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic                     i_re,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) r_mem[i_waddr] <= i_wdata;
        if (i_re) o_rdata <= r_mem[i_raddr];
    end
endmodule
`default_nettype wire

// ===== rtl/core/amf_rank.sv =====
`default_nettype none
module amf_rank (
    input  wire logic                          i_clk,
    input  wire amf_pkg::t_ins                 i_ins,
    input  wire logic [amf_pkg::WIN_BITS-1:0]  i_start_win,
    output amf_pkg::t_decision                 o_dec
);
    import amf_pkg::*;

    // Three running insertion sorts, one per window size.
    logic [PIXEL_BITS-1:0] r_s3 [N3];
    logic [PIXEL_BITS-1:0] r_s5 [N5];
    logic [PIXEL_BITS-1:0] r_s7 [N7];
    logic [N3-1:0] r_v3, le3;
    logic [N5-1:0] r_v5, le5;
    logic [N7-1:0] r_v7, le7;
    logic [PIXEL_BITS-1:0] r_cur;

    always_comb begin
        for (int i = 0; i < N3; i++) le3[i] = r_v3[i] && (r_s3[i] <= i_ins.value);
        for (int i = 0; i < N5; i++) le5[i] = r_v5[i] && (r_s5[i] <= i_ins.value);
        for (int i = 0; i < N7; i++) le7[i] = r_v7[i] && (r_s7[i] <= i_ins.value);
    end

    always_ff @(posedge i_clk) begin
        if (i_ins.clear) begin
            r_v3 <= '0;
            r_v5 <= '0;
            r_v7 <= '0;
        end else if (i_ins.valid) begin
            if (i_ins.centre) r_cur <= i_ins.value;
            if (i_ins.in3) begin
                if (!le3[0]) r_s3[0] <= i_ins.value;
                for (int i = 1; i < N3; i++) begin
                    if (!le3[i]) r_s3[i] <= le3[i-1] ? i_ins.value : r_s3[i-1];
                end
                r_v3 <= {r_v3[N3-2:0], 1'b1};
            end
            if (i_ins.in5) begin
                if (!le5[0]) r_s5[0] <= i_ins.value;
                for (int i = 1; i < N5; i++) begin
                    if (!le5[i]) r_s5[i] <= le5[i-1] ? i_ins.value : r_s5[i-1];
                end
                r_v5 <= {r_v5[N5-2:0], 1'b1};
            end
            if (!le7[0]) r_s7[0] <= i_ins.value;
            for (int i = 1; i < N7; i++) begin
                if (!le7[i]) r_s7[i] <= le7[i-1] ? i_ins.value : r_s7[i-1];
            end
            r_v7 <= {r_v7[N7-2:0], 1'b1};
        end
    end

    logic ok3, ok5, ok7, ok_sel;
    logic [PIXEL_BITS-1:0] mn, md, mx;

    always_comb begin
        ok3 = (r_s3[0] < r_s3[N3/2]) && (r_s3[N3/2] < r_s3[N3-1]);
        ok5 = (r_s5[0] < r_s5[N5/2]) && (r_s5[N5/2] < r_s5[N5-1]);
        ok7 = (r_s7[0] < r_s7[N7/2]) && (r_s7[N7/2] < r_s7[N7-1]);
        mn = r_s7[0];
        md = r_s7[N7/2];
        mx = r_s7[N7-1];
        o_dec.win = WIN7;
        ok_sel = ok7;
        if (i_start_win == WIN3 && ok3) begin
            mn = r_s3[0];
            md = r_s3[N3/2];
            mx = r_s3[N3-1];
            o_dec.win = WIN3;
            ok_sel = 1'b1;
        end else if (i_start_win != WIN7 && ok5) begin
            mn = r_s5[0];
            md = r_s5[N5/2];
            mx = r_s5[N5-1];
            o_dec.win = WIN5;
            ok_sel = 1'b1;
        end
        o_dec.kept  = ok_sel && (mn < r_cur) && (r_cur < mx);
        o_dec.pixel = o_dec.kept ? r_cur : md;
    end
endmodule
`default_nettype wire
